// ===== design/aes128_key_expansion_core_defines.svh =====
// Assertion macros for the AES-128 key expansion core.
// Used by the checker module only.
`ifndef AES128_KEY_EXPANSION_CORE_DEFINES_SVH
`define AES128_KEY_EXPANSION_CORE_DEFINES_SVH
`define AKE_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AKE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/ake_pkg.sv =====
// Package for the AES-128 key expansion core: widths, stage type, S-box and xtime.
// No dependencies.
package ake_pkg;
  localparam int KeyHalfW = 64;
  localparam int RoundW = 4;
  localparam int RoundCount = 11;
  localparam logic [RoundW-1:0] LastRound = 4'd10;

  typedef struct packed {
    logic [RoundW-1:0] round_index;
    logic [31:0] rcon;
    logic [127:0] rkey;
  } stage_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction
endpackage

// ===== design/ake_round.sv =====
// One key expansion round with an output register, its own valid bit and stall.
// Depends on ake_pkg.
module ake_round import ake_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  stage_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output stage_t out_data
);
  logic [31:0] w0, w1, w2, w3, rot, g;
  stage_t nxt;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    {w0, w1, w2, w3} = in_data.rkey;
    rot = {w3[23:0], w3[31:24]};
    g = {sbox(rot[31:24]), sbox(rot[23:16]), sbox(rot[15:8]), sbox(rot[7:0])}
        ^ {in_data.rcon[7:0], 24'd0};
    w0 = w0 ^ g;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    nxt.rkey = {w0, w1, w2, w3};
    nxt.rcon = {24'd0, xtime(in_data.rcon[7:0])};
    nxt.round_index = in_data.round_index + RoundW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end
endmodule

// ===== design/aes128_key_expansion_core.sv =====
// AES-128 key expansion core: ten registered rounds and an output sequencer.
// Depends on ake_pkg and ake_round.
//
// Usage:
//  A key request on the slave side (s_tdata = key_high, key_low) runs through
//  a chain of ten round stages, one register each. All eleven round keys
//  (the key itself and rounds 1 to 10) reach the end together.
//  The output stage sends them one a cycle while m_tready is high on the master
//  side, round 0 first; m_tlast marks round 10.
//  Path: a key passes the ten round registers, then the output key register.
//  Throughput: the single result channel emits eleven round keys per key and
//  loads the next key as the last is taken; the chain takes one key a cycle
//  when not stalled. Stalls: when m_tready is low the current round key holds;
//  the chain fills and s_tready falls. Nothing is lost or repeated.
//  Reset (rst, synchronous) empties all stages.
module aes128_key_expansion_core import ake_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // key_high [63:0], key_low [127:64]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // round_index [3:0], round_key_high [67:4],
                                  // round_key_low [131:68], zero [135:132]
  output logic         m_tlast
);
  localparam int Stages = RoundCount - 1;

  logic   v [Stages+1];
  logic   r [Stages+1];
  stage_t d [Stages+1];
  logic [127:0] keys [RoundCount];
  logic [127:0] keys_next [RoundCount];
  logic [RoundW-1:0] cnt;
  logic hold;

  assign v[0] = s_tvalid;
  assign s_tready = r[0];
  assign d[0].round_index = '0;
  assign d[0].rcon = 32'd1;
  assign d[0].rkey = {s_tdata[63:0], s_tdata[127:64]};

  for (genvar i = 0; i < Stages; i++) begin : g_round
    ake_round u_round (
      .clk, .rst,
      .in_valid(v[i]), .in_ready(r[i]), .in_data(d[i]),
      .out_valid(v[i+1]), .out_ready(r[i+1]), .out_data(d[i+1])
    );
  end

  // Keys of earlier rounds travel alongside each stage.
  for (genvar i = 0; i < Stages; i++) begin : g_side
    logic [127:0] kept [i+1];
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (r[0] && v[0]) begin
          kept[0] <= d[0].rkey;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (r[i] && v[i]) begin
          for (int j = 0; j < i; j++) kept[j] <= g_side[i-1].kept[j];
          kept[i] <= d[i].rkey;
        end
      end
    end
  end

  assign hold = m_tvalid;
  assign r[Stages] = !hold || (m_tready && cnt == LastRound);

  always_comb begin
    for (int k = 0; k < Stages; k++) keys_next[k] = g_side[Stages-1].kept[k];
    keys_next[Stages] = d[Stages].rkey;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      cnt <= '0;
    end else if (r[Stages] && v[Stages]) begin
      m_tvalid <= 1'b1;
      cnt <= '0;
    end else if (m_tvalid && m_tready) begin
      if (cnt == LastRound) begin
        m_tvalid <= 1'b0;
      end else begin
        cnt <= cnt + RoundW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r[Stages] && v[Stages]) keys <= keys_next;
  end

  always_comb begin
    m_tdata = {4'd0, keys[cnt][63:0], keys[cnt][127:64], cnt};
    m_tlast = (cnt == LastRound);
  end
endmodule

// ===== design/ake_checker.sv =====
// Port-level checker for the AES-128 key expansion core, bound to the top level.
// Depends on aes128_key_expansion_core_defines.svh and ake_pkg.
`include "aes128_key_expansion_core_defines.svh"
module ake_checker import ake_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata,
  input logic         m_tlast
);
  `AKE_ASSERT_IMPL(a_last_idx, clk, rst, m_tvalid, m_tlast == (m_tdata[3:0] == LastRound))
  `AKE_ASSERT_NEXT(a_step, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1)
  `AKE_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `AKE_ASSERT_IMPL(a_ready_idle, clk, rst, s_tvalid && !m_tvalid, s_tready)
endmodule

bind aes128_key_expansion_core ake_checker u_ake_checker (.*);

// ===== test/tb_top.sv =====
// Testbench for aes128_key_expansion_core: random and directed AES-128 keys, checked
// against a behavioural key schedule. Depends on ake_pkg and the core RTL.
`timescale 1ns / 1ps

class round_key_board;
  typedef struct {
    logic [3:0]  idx;
    logic [63:0] khi;
    logic [63:0] klo;
    logic        lst;
  } rkey_t;

  rkey_t pending[$];
  int errors = 0;
  int keys_seen = 0;
  int rkeys_seen = 0;

  static function logic [7:0] sub_byte(input logic [7:0] a);
    logic [7:0] inv;
    logic [7:0] p;
    logic [7:0] b;
    logic [7:0] s;
    inv = 8'h00;
    if (a != 8'h00) begin
      for (int c = 1; c < 256; c++) begin
        p = 8'h00;
        b = a;
        for (int k = 0; k < 8; k++) begin
          if (c[k]) p ^= b;
          b = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
        end
        if (p == 8'h01) inv = c[7:0];
      end
    end
    for (int k = 0; k < 8; k++)
      s[k] = inv[k] ^ inv[(k + 4) % 8] ^ inv[(k + 5) % 8] ^ inv[(k + 6) % 8]
             ^ inv[(k + 7) % 8];
    return s ^ 8'h63;
  endfunction

  function void note_key(input logic [63:0] khi, input logic [63:0] klo);
    logic [31:0] w[4];
    logic [31:0] rot;
    logic [31:0] g;
    logic [7:0]  rc;
    rkey_t e;
    w[0] = khi[63:32]; w[1] = khi[31:0]; w[2] = klo[63:32]; w[3] = klo[31:0];
    rc = 8'h01;
    keys_seen++;
    for (int r = 0; r < 11; r++) begin
      if (r > 0) begin
        rot = {w[3][23:0], w[3][31:24]};
        g = {sub_byte(rot[31:24]) ^ rc, sub_byte(rot[23:16]), sub_byte(rot[15:8]),
             sub_byte(rot[7:0])};
        w[0] ^= g; w[1] ^= w[0]; w[2] ^= w[1]; w[3] ^= w[2];
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      e.idx = r[3:0];
      e.khi = {w[0], w[1]};
      e.klo = {w[2], w[3]};
      e.lst = (r == 10);
      pending.push_back(e);
    end
  endfunction

  function void check_round_key(input logic [135:0] d, input logic lst);
    rkey_t e;
    rkeys_seen++;
    if (pending.size() == 0) begin
      $error("round key with nothing expected: %h", d);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (d[3:0] !== e.idx) begin
      $error("round_index exp %0d got %0d", e.idx, d[3:0]); errors++;
    end
    if (d[67:4] !== e.khi) begin
      $error("round_key_high exp %h got %h", e.khi, d[67:4]); errors++;
    end
    if (d[131:68] !== e.klo) begin
      $error("round_key_low exp %h got %h", e.klo, d[131:68]); errors++;
    end
    if (d[135:132] !== 4'h0) begin
      $error("pad exp 0 got %h", d[135:132]); errors++;
    end
    if (lst !== e.lst) begin
      $error("last exp %b got %b", e.lst, lst); errors++;
    end
  endfunction
endclass

module tb_top;
  import ake_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;
  logic         m_tlast;

  round_key_board board;
  int idle_cycles;

  aes128_key_expansion_core DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_key(input logic [63:0] khi, input logic [63:0] klo);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {klo, khi};
    do @(posedge clk); while (!s_tready);
    board.note_key(khi, klo);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int stall;
    board = new();
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) board.check_round_key(m_tdata, m_tlast);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] h;
    logic [63:0] l;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, the FIPS-197 example key, walking ones
    send_key(64'h0, 64'h0);
    send_key('1, '1);
    send_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    send_key(64'h8000000000000000, 64'h0000000000000001);
    for (int i = 0; i < 8; i++) begin
      send_key(64'h1 << (i * 8 + 3), 64'h1 << (63 - i * 8));
    end
    // hold off until all round keys are out
    wait_drained();
    for (int i = 0; i < 200; i++) begin
      h = {$urandom, $urandom};
      l = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) h = ~h;
      send_key(h, l);
      if (i == 100) wait_drained();
    end
    wait_drained();
    repeat (30) @(posedge clk);
    $display("Covered %0d keys, %0d round keys checked, with random stalls on both sides.",
             board.keys_seen, board.rkeys_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
